[rtl/msx_pkg.sv]
// Package with the fixed port widths and payload types of the maximum subset XOR unit.
`timescale 1ns / 1ps

package msx_pkg;

    // Fixed widths of the request and result ports.
    localparam int IN_WORD_BITS  = 32;
    localparam int OUT_WORD_BITS = 32;

    typedef logic [IN_WORD_BITS-1:0]  t_in_word;
    typedef logic [OUT_WORD_BITS-1:0] t_out_word;

endpackage

[rtl/msx_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module msx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/max_subset_xor_unit.sv]
// Top level of the maximum subset XOR unit: linear basis builder and greedy maximizer.
`timescale 1ns / 1ps

// Channel   | Direction | Handshake                      | Payload
// ----------+-----------+--------------------------------+-----------------------------
// request   | in        | start high while busy is low   | i_word, i_last
// result    | out       | o_valid strobe, one cycle      | o_max_xor, o_overflow
//
// Each stored word is reduced against a GF(2) basis held in a small RAM, one bit
// per cycle from the top bit down, with busy high for the whole pass. A request
// with i_last set then runs a second pass that greedily builds the maximum;
// o_valid pulses in the same cycle as busy falls. The single registered read
// port of the basis RAM sets the one-bit-per-cycle pace. A word that arrives
// when MAX_ITEMS words are already held is not stored and does not make the
// unit busy unless it is the last one. Reset is synchronous and clears the
// count, the overflow flag and the basis valid bits; the result side cannot stall.
module max_subset_xor_unit #(
    parameter int MAX_ITEMS = 64,
    parameter int WORD_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  msx_pkg::t_in_word   i_word,
    input  logic                i_last,
    output logic                o_valid,
    output msx_pkg::t_out_word  o_max_xor,
    output logic                o_overflow
);

    import msx_pkg::*;

    localparam int BIT_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic [BIT_W-1:0] TOP_BIT = BIT_W'(WORD_BITS - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_INS  = 2'd1;
    localparam logic [1:0] S_QRY  = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_dropped, n_dropped;
    logic                 r_last, n_last;
    logic [WORD_BITS-1:0] r_cur, n_cur;
    logic                 r_done, n_done;
    logic [WORD_BITS-1:0] r_bvalid, n_bvalid;
    logic [BIT_W-1:0]     r_rd_bit, n_rd_bit;
    logic                 r_rd_act, n_rd_act;
    logic [BIT_W-1:0]     r_pr_bit, n_pr_bit;
    logic                 r_pr_vld, n_pr_vld;
    logic                 r_out_vld, n_out_vld;
    t_out_word            r_out_word, n_out_word;
    logic                 r_out_ovf, n_out_ovf;

    logic                 w_accept;
    logic [WORD_BITS-1:0] w_word;
    logic [WORD_BITS-1:0] w_basis;
    logic                 w_wr_en;
    logic [WORD_BITS-1:0] w_cur_step;
    logic                 w_pass_end;
    t_out_word            w_res_out;

    // Bring the request word to the internal width and the result to the output width.
    generate
        if (WORD_BITS <= IN_WORD_BITS) begin : g_in_trunc
            assign w_word = i_word[WORD_BITS-1:0];
        end else begin : g_in_ext
            assign w_word = {{(WORD_BITS - IN_WORD_BITS){1'b0}}, i_word};
        end
        if (WORD_BITS >= OUT_WORD_BITS) begin : g_out_trunc
            assign w_res_out = w_cur_step[OUT_WORD_BITS-1:0];
        end else begin : g_out_ext
            assign w_res_out = {{(OUT_WORD_BITS - WORD_BITS){1'b0}}, w_cur_step};
        end
    endgenerate

    // The basis row for bit b has its leading one at bit b. Reads stream from the
    // top bit down; the row for r_pr_bit is on the read port while the next row
    // is being fetched.
    msx_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_BITS),
        .ADDR_W(BIT_W)
    ) u_basis (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(r_pr_bit),
        .i_wr_data(r_cur),
        .i_rd_addr(r_rd_bit),
        .o_rd_data(w_basis)
    );

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // One reduction step of the shared XOR unit. While inserting, a word whose
    // current top bit has no basis row becomes that row. While maximizing, a row
    // is folded in whenever it raises the running value, i.e. when the running
    // value lacks the row's leading bit.
    always_comb begin
        w_wr_en    = 1'b0;
        w_cur_step = r_cur;
        if (r_pr_vld) begin
            if (r_state == S_INS) begin
                if (!r_done && r_cur[r_pr_bit]) begin
                    if (r_bvalid[r_pr_bit]) begin
                        w_cur_step = r_cur ^ w_basis;
                    end else begin
                        w_wr_en = 1'b1;
                    end
                end
            end else if (r_state == S_QRY) begin
                if (r_bvalid[r_pr_bit] && !r_cur[r_pr_bit]) begin
                    w_cur_step = r_cur ^ w_basis;
                end
            end
        end
    end

    assign w_pass_end = r_pr_vld && (r_pr_bit == '0);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_dropped  = r_dropped;
        n_last     = r_last;
        n_cur      = w_cur_step;
        n_done     = r_done;
        n_bvalid   = r_bvalid;
        n_rd_bit   = r_rd_bit;
        n_rd_act   = r_rd_act;
        n_pr_bit   = r_pr_bit;
        n_pr_vld   = 1'b0;
        n_out_vld  = 1'b0;
        n_out_word = r_out_word;
        n_out_ovf  = r_out_ovf;

        // Read address stream: one row per cycle, top bit first.
        if (r_rd_act) begin
            n_pr_vld = 1'b1;
            n_pr_bit = r_rd_bit;
            if (r_rd_bit == '0) begin
                n_rd_act = 1'b0;
            end else begin
                n_rd_bit = r_rd_bit - 1'b1;
            end
        end

        if (w_wr_en) begin
            n_bvalid[r_pr_bit] = 1'b1;
            n_done             = 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_last   = i_last;
                    n_rd_bit = TOP_BIT;
                    n_rd_act = 1'b1;
                    n_done   = 1'b0;
                    if (r_count < CNT_MAX) begin
                        n_count = r_count + 1'b1;
                        n_cur   = w_word;
                        n_state = S_INS;
                    end else begin
                        n_dropped = 1'b1;
                        n_cur     = '0;
                        n_state   = i_last ? S_QRY : S_IDLE;
                        n_rd_act  = i_last;
                    end
                end
            end
            S_INS: begin
                if (w_pass_end) begin
                    n_cur    = '0;
                    n_rd_bit = TOP_BIT;
                    n_rd_act = r_last;
                    n_state  = r_last ? S_QRY : S_IDLE;
                end
            end
            S_QRY: begin
                if (w_pass_end) begin
                    n_out_vld  = 1'b1;
                    n_out_word = w_res_out;
                    n_out_ovf  = r_dropped;
                    n_count    = '0;
                    n_dropped  = 1'b0;
                    n_bvalid   = '0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_bvalid  <= '0;
            r_rd_act  <= 1'b0;
            r_pr_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_done    <= 1'b0;
            r_last    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
            r_bvalid  <= n_bvalid;
            r_rd_act  <= n_rd_act;
            r_pr_vld  <= n_pr_vld;
            r_out_vld <= n_out_vld;
            r_done    <= n_done;
            r_last    <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_rd_bit   <= n_rd_bit;
        r_pr_bit   <= n_pr_bit;
        r_out_word <= n_out_word;
        r_out_ovf  <= n_out_ovf;
    end

    assign o_valid    = r_out_vld;
    assign o_max_xor  = r_out_word;
    assign o_overflow = r_out_ovf;

    // The stored word count never exceeds the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("element count exceeds capacity");

    // A basis row is written only into an empty slot, and only once per word.
    a_write_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (!r_bvalid[r_pr_bit] && !r_done && r_state == S_INS))
        else $error("basis row overwritten");

    // A result comes only at the end of a maximize pass, and the set is emptied.
    a_result_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_count == '0 && !r_dropped && r_bvalid == '0 && !busy))
        else $error("set not emptied after result");

    // The result strobe lasts exactly one cycle.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // A stored request always makes the unit busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_count < CNT_MAX) |=> busy)
        else $error("stored request did not start a pass");

endmodule
